### sv/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// shared types and constants for the heron square root block
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int unsigned DATA_W                 = 32;
  localparam int unsigned ITER_W                 = 7;
  localparam int unsigned MAX_ITERATIONS_DEFAULT = 64;

  // 1.0 in unsigned q16.16
  localparam logic [DATA_W-1:0] ONE_Q16    = 32'h0001_0000;
  localparam logic [ITER_W-1:0] ITER_RESET = 7'd16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture radicand, guess back to 1.0
    logic start;  // launch one division radicand / guess
    logic step;   // fold the quotient into the guess
    logic emit;   // copy the guess into the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

### sv/nsr_div.sv
// ----------------------------------------------------------------------------
// nsr_div
// serial restoring divider: (radicand << 16) / divisor, one quotient bit per
// cycle, saturating to all ones, zero for a zero divisor
// ----------------------------------------------------------------------------
module nsr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [nsr_pkg::DATA_W-1:0] radicand_i,
  input  logic [nsr_pkg::DATA_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [nsr_pkg::DATA_W-1:0] quotient_o
);
  import nsr_pkg::*;

  localparam int unsigned HALF_W = DATA_W / 2;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  logic                active_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DATA_W-1:0]   rem_q;
  logic [DATA_W-1:0]   shreg_q;   // low dividend bits in, quotient bits out
  logic [DATA_W:0]     trial;
  logic                fits;
  logic                overflow;

  // quotient needs more than 32 bits when the high half of the radicand
  // already reaches the divisor
  assign overflow = {{HALF_W{1'b0}}, radicand_i[DATA_W-1:HALF_W]} >= divisor_i;
  assign trial    = {rem_q, shreg_q[DATA_W-1]};
  assign fits     = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (divisor_i == '0) begin
          shreg_q <= '0;
          done_q  <= 1'b1;
        end else if (overflow) begin
          shreg_q <= '1;
          done_q  <= 1'b1;
        end else begin
          rem_q    <= {{HALF_W{1'b0}}, radicand_i[DATA_W-1:HALF_W]};
          shreg_q  <= {radicand_i[HALF_W-1:0], {HALF_W{1'b0}}};
          cnt_q    <= CNT_W'(DATA_W - 1);
          active_q <= 1'b1;
        end
      end else if (active_q) begin
        if (fits) begin
          rem_q <= DATA_W'(trial - {1'b0, divisor_i});
        end else begin
          rem_q <= trial[DATA_W-1:0];
        end
        shreg_q <= {shreg_q[DATA_W-2:0], fits};
        if (cnt_q == '0) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shreg_q;

`ifndef NO_ASSERTIONS
  // a new division never lands on one still running
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !active_q) else $error("divider restarted while busy");

  // the last quotient bit is followed by done
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && !start_i && cnt_q == '0 |=> done_q && !active_q)
    else $error("divider did not finish");
`endif

endmodule

### sv/nsr_datapath.sv
// ----------------------------------------------------------------------------
// nsr_datapath
// radicand and guess registers, the divider and the output register
// ----------------------------------------------------------------------------
module nsr_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nsr_pkg::cmd_t              cmd_i,
  output nsr_pkg::status_t           status_o,
  input  logic [nsr_pkg::DATA_W-1:0] radicand_i,
  output logic [nsr_pkg::DATA_W-1:0] root_o
);
  import nsr_pkg::*;

  logic [DATA_W-1:0] radicand_q;
  logic [DATA_W-1:0] guess_q;
  logic [DATA_W-1:0] root_q;
  logic [DATA_W-1:0] quotient;
  logic [DATA_W:0]   sum;
  logic              div_done;

  nsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .radicand_i (radicand_q),
    .divisor_i  (guess_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // 33-bit sum, halved by dropping the low bit
  assign sum = {1'b0, guess_q} + {1'b0, quotient};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      radicand_q <= radicand_i;
      guess_q    <= ONE_Q16;
    end else if (cmd_i.step) begin
      guess_q <= sum[DATA_W:1];
    end
    if (cmd_i.emit) begin
      root_q <= guess_q;
    end
  end

  assign status_o.div_done = div_done;
  assign root_o            = root_q;

endmodule

### sv/nsr_ctrl.sv
// ----------------------------------------------------------------------------
// nsr_ctrl
// sequencer: input and output handshakes, iteration count, divider launches
// ----------------------------------------------------------------------------
module nsr_ctrl #(
  parameter int unsigned MaxIterations = nsr_pkg::MAX_ITERATIONS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [nsr_pkg::ITER_W-1:0] iteration_count_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output nsr_pkg::cmd_t              cmd_o,
  input  nsr_pkg::status_t           status_i
);
  import nsr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MaxIterations + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_init;
  logic             out_valid_q;
  cmd_t             cmd;

  // iteration count saturates at the maximum
  always_comb begin
    if (32'(iteration_count_i) > 32'(MaxIterations)) begin
      cnt_init = CNT_W'(MaxIterations);
    end else begin
      cnt_init = CNT_W'(iteration_count_i);
    end
  end

  assign cmd.load  = (state_q == S_IDLE) && in_valid_i;
  assign cmd.start = (state_q == S_START);
  assign cmd.step  = (state_q == S_WAIT) && status_i.div_done;
  assign cmd.emit  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cnt_q   <= cnt_init;
            state_q <= (cnt_init == '0) ? S_DONE : S_START;
          end
        end
        S_START: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (status_i.div_done) begin
            cnt_q   <= cnt_q - CNT_W'(1);
            state_q <= (cnt_q == CNT_W'(1)) ? S_DONE : S_START;
          end
        end
        S_DONE: begin
          if (cmd.emit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef NO_ASSERTIONS
  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !cmd.emit) else $error("result overwritten");

  // division results only arrive while the sequencer waits for one
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> state_q == S_WAIT) else $error("stray divider done");

  // a division is only launched with iterations left
  a_cnt_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_START |-> cnt_q != '0) else $error("launch with no iterations left");
`endif

endmodule

### sv/newton_square_root.sv
// ----------------------------------------------------------------------------
// newton_square_root
// square root of an unsigned q16.16 radicand by heron (newton) iteration
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    radicand_i  [31:0] q16.16
//   out      output     out_valid_o / out_ready_i  root_o      [31:0] q16.16
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_data_i  [6:0]  iterations
//
// - one item at a time, n iterations with n the iteration count capped
//   at MaxIterations; each iteration is one pass of the shared serial divider
//   (launch, 32 quotient bits, done) with the guess update on the done cycle
// - a zero guess or an overflowing quotient ends its iteration without the serial quotient bits
// - with n = 0 the sequencer skips the divider and the root is 1.0
// - reset sets the iteration count to 16 and empties the output register
// - a stalled output holds the result; the next radicand is taken meanwhile
//   and its result waits until the output register frees up
//
module newton_square_root #(
  parameter int unsigned MaxIterations = nsr_pkg::MAX_ITERATIONS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // radicand channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [nsr_pkg::DATA_W-1:0] radicand_i,
  // root channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [nsr_pkg::DATA_W-1:0] root_o,
  // iteration count register
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [nsr_pkg::ITER_W-1:0] cfg_data_i
);
  import nsr_pkg::*;

  logic [ITER_W-1:0] iter_q;
  cmd_t              cmd;
  status_t           status;

  // configuration register, always ready for a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= ITER_RESET;
    end else if (cfg_valid_i) begin
      iter_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // sequencer
  nsr_ctrl #(
    .MaxIterations (MaxIterations)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .iteration_count_i (iter_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .cmd_o             (cmd),
    .status_i          (status)
  );

  // guess, divider and result registers
  nsr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .radicand_i (radicand_i),
    .root_o     (root_o)
  );

`ifndef NO_ASSERTIONS
  // an accepted radicand starts work: the sequencer leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("accepted item dropped");
`endif

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the heron square root block: every radicand is
// predicted in q16.16 with the current iteration count, and each root that
// leaves the block is compared in order against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;

  import nsr_pkg::*;

  // run length guard, well above the slowest legal run
  localparam int unsigned CYCLE_LIMIT    = 3_000_000;
  // quiet time after the last root, a bit more than one full-length item
  localparam int unsigned TAIL_CYCLES    = 2400;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned RANDOM_ITEMS   = 240;
  localparam int unsigned HOLD_OFF_LEN   = 600;

  typedef enum logic [1:0] {
    SINK_STEADY,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_e;

  // one predicted root, with what produced it for the mismatch report
  typedef struct {
    logic [DATA_W-1:0] radicand;
    logic [ITER_W-1:0] iterations;
    logic [DATA_W-1:0] root;
  } root_want_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [DATA_W-1:0] radicand_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [DATA_W-1:0] root_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [ITER_W-1:0] cfg_data_i;

  // bench mirror of the iteration count register
  logic [ITER_W-1:0] iter_count_q;
  root_want_t        pending_roots[$];

  sink_mode_e  sink_mode        = SINK_STEADY;
  int unsigned hold_off_request = 0;

  int unsigned fail_cnt       = 0;
  int unsigned roots_checked  = 0;
  int unsigned items_sent     = 0;
  int unsigned cfg_writes     = 0;
  int unsigned hold_offs_done = 0;
  int unsigned cycle_cnt      = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  newton_square_root #(
    .MaxIterations(MAX_ITERATIONS_DEFAULT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .radicand_i (radicand_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .root_o     (root_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // heron iteration in q16.16: guess = (guess + radicand / guess) / 2,
  // count capped at the block's maximum, zero guess gives zero quotient
  function automatic logic [DATA_W-1:0] heron_root(input logic [DATA_W-1:0] rad,
                                                   input logic [ITER_W-1:0] iters);
    logic [DATA_W-1:0] guess;
    logic [63:0]       quot;
    logic [DATA_W:0]   sum;
    int unsigned       n;
    guess = ONE_Q16;
    n = (iters > MAX_ITERATIONS_DEFAULT) ? MAX_ITERATIONS_DEFAULT : iters;
    for (int unsigned k = 0; k < n; k++) begin
      if (guess == '0) begin
        quot = '0;
      end else begin
        quot = {16'h0, rad, 16'h0} / {32'h0, guess};
        // quotient wider than 32 bits saturates
        if (quot > 64'hFFFF_FFFF) begin
          quot = 64'hFFFF_FFFF;
        end
      end
      // 33-bit sum, halved by truncating shift
      sum   = {1'b0, guess} + {1'b0, quot[DATA_W-1:0]};
      guess = sum[DATA_W:1];
    end
    return guess;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // offer one radicand and hold it until the transfer, then log the prediction
  task automatic send_radicand(input logic [DATA_W-1:0] value);
    root_want_t want;
    in_valid_i <= 1'b1;
    radicand_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    want.radicand   = value;
    want.iterations = iter_count_q;
    want.root       = heron_root(value, iter_count_q);
    pending_roots.push_back(want);
    items_sent++;
  endtask

  // sender drops valid and waits out the requested pause; zero keeps valid up for the next item
  task automatic sender_pause(input int unsigned n);
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every predicted root has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk_i);
  endtask

  // block is idle once drained, since every radicand gives exactly one root
  task automatic write_iteration_count(input logic [ITER_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    iter_count_q = value;
    cfg_writes++;
  endtask

  // mixes full-range, fractional, perfect squares and boundary values
  function automatic logic [DATA_W-1:0] pick_radicand();
    logic [DATA_W-1:0] k;
    k = $urandom_range(0, 255);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom() >> $urandom_range(1, 31);
      2: return (k * k) << 16;
      3: return $urandom_range(0, 32'hFFFF);
      4: begin
        case ($urandom_range(0, 5))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hFFFF_FFFF;
          3: return ONE_Q16;
          4: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      default: return ((k * k) << 16) ^ $urandom_range(0, 255);
    endcase
  endfunction

  // mostly short counts, now and then zero, full length or above the cap
  function automatic logic [ITER_W-1:0] pick_iterations();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return ITER_W'(MAX_ITERATIONS_DEFAULT);
    if (r == 2) return ITER_W'($urandom_range(MAX_ITERATIONS_DEFAULT + 1, 127));
    if (r < 16) return ITER_W'($urandom_range(1, 10));
    return ITER_W'($urandom_range(11, 24));
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 3) == 0) return $urandom_range(20, 300);
    return $urandom_range(1, 15);
  endfunction

  // --------------------------------------------------------------------------
  // test tasks
  // --------------------------------------------------------------------------

  // reset count of 16, radicand extremes and alternating bits
  task automatic test_reset_count();
    send_radicand(32'h0000_0000);
    send_radicand(32'h0000_0001);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(ONE_Q16);
    send_radicand(32'h0004_0000);
    send_radicand(32'h8000_0000);
    send_radicand(32'hAAAA_AAAA);
    send_radicand(32'h5555_5555);
    send_radicand(32'h0000_FFFF);
  endtask

  // no iterations at all, root must stay at 1.0
  task automatic test_zero_iterations();
    write_iteration_count('0);
    send_radicand(32'h0000_0000);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h0009_0000);
  endtask

  // all-ones count is capped; a zero radicand halves the guess down to zero
  task automatic test_count_saturation();
    write_iteration_count('1);
    send_radicand(32'h0000_0000);
    send_radicand(32'h0000_0001);
    send_radicand(32'hFFFF_FFFF);
    write_iteration_count(ITER_W'(MAX_ITERATIONS_DEFAULT));
    send_radicand(32'h0000_0000);
    send_radicand(32'h0019_0000);
  endtask

  task automatic test_single_iteration();
    write_iteration_count(7'd1);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h0000_0002);
  endtask

  // receiver holds off while the sender keeps offering, so the output
  // register fills and the input stalls behind it
  task automatic test_output_hold_off();
    write_iteration_count(7'd2);
    sink_mode        = SINK_STEADY;
    hold_off_request = HOLD_OFF_LEN;
    repeat (8) send_radicand(pick_radicand());
    wait_drained();
  endtask

  // sender stops until everything has come back, then resumes
  task automatic test_drain_pause();
    write_iteration_count(7'd5);
    sink_mode = SINK_PATTERN;
    repeat (6) send_radicand(pick_radicand());
    wait_drained();
    sender_pause($urandom_range(1, 20));
    repeat (6) send_radicand(pick_radicand());
  endtask

  // phases of random settings, bursty sender, changing receiver behavior
  task automatic test_random_settings();
    int unsigned       done_items;
    int unsigned       phase_items;
    int unsigned       burst_left;
    logic [ITER_W-1:0] iters;
    done_items = 0;
    burst_left = $urandom_range(1, 8);
    while (done_items < RANDOM_ITEMS) begin
      iters = pick_iterations();
      write_iteration_count(iters);
      sink_mode = sink_mode_e'($urandom_range(0, 2));
      // long counts are slow, keep those phases short
      phase_items = (iters >= 40) ? $urandom_range(4, 6) : $urandom_range(15, 25);
      repeat (phase_items) begin
        send_radicand(pick_radicand());
        done_items++;
        burst_left--;
        if (burst_left == 0) begin
          sender_pause(pick_gap());
          burst_left = $urandom_range(1, 8);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // root checker, in order against the oldest prediction
  // --------------------------------------------------------------------------

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= REPORT_LIMIT) begin
      $display("[%0d] %s", cycle_cnt, msg);
    end
  endtask

  always @(posedge clk_i) begin
    root_want_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_roots.size() == 0) begin
        note_failure($sformatf("unexpected root %h with nothing outstanding", root_o));
      end else begin
        want = pending_roots.pop_front();
        roots_checked++;
        if (root_o !== want.root) begin
          note_failure($sformatf("root mismatch: radicand %h iterations %0d expected %h got %h",
                                 want.radicand, want.iterations, want.root, root_o));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: steady, random or rotating stall mask, plus counted hold-offs
  // --------------------------------------------------------------------------

  initial begin : sink_driver
    int unsigned hold_len;
    int unsigned mask_age;
    logic [15:0] ready_mask;
    mask_age   = 0;
    ready_mask = 16'hF3B5;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_request != 0) begin
        hold_len         = hold_off_request;
        hold_off_request = 0;
        out_ready_i <= 1'b0;
        while (hold_len != 0) begin
          @(posedge clk_i);
          hold_len--;
        end
        hold_offs_done++;
      end else begin
        case (sink_mode)
          SINK_STEADY: out_ready_i <= 1'b1;
          SINK_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: begin
            out_ready_i <= ready_mask[0];
            ready_mask = {ready_mask[0], ready_mask[15:1]};
            mask_age++;
            // fresh mask now and then, never all stalls
            if (mask_age == 64) begin
              mask_age   = 0;
              ready_mask = $urandom() | 16'h0001;
            end
          end
        endcase
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    radicand_i   <= '0;
    out_ready_i  <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_data_i   <= '0;
    iter_count_q = ITER_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_count();
    test_zero_iterations();
    test_count_saturation();
    test_single_iteration();
    test_output_hold_off();
    test_drain_pause();
    test_random_settings();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d radicands over %0d iteration-count writes, %0d roots checked",
             items_sent, cfg_writes, roots_checked);
    $display("output hold-offs: %0d, mismatches: %0d", hold_offs_done, fail_cnt);
    if (fail_cnt == 0 && pending_roots.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/nsr_pkg.sv
sv/nsr_div.sv
sv/nsr_datapath.sv
sv/nsr_ctrl.sv
sv/newton_square_root.sv
bench/tb_top.sv
